@@ hdl/ufma_pkg.sv @@
// ----------------------------------------------------------------------------
// ufma_pkg
// Types, constants and helper functions for the unrounded fused multiply-add.
// ----------------------------------------------------------------------------
package ufma_pkg;

  localparam int NormPos = 62;
  localparam int MantW   = 63;
  localparam int InExpW  = 13;
  localparam int ExpW    = 16;
  localparam int OutExpW = 15;
  localparam int WideW   = 128;
  localparam int PosW    = 7;
  localparam int Latency = 8;

  typedef logic signed [ExpW-1:0] exp_t;
  typedef logic [MantW-1:0]       mant_t;
  typedef logic [WideW-1:0]       wide_t;

  typedef struct packed {
    logic  sign;
    exp_t  exponent;
    mant_t mantissa;
  } operand_t;

  function automatic logic [PosW-1:0] top_bit(input logic [63:0] x);
    logic [PosW-1:0] pos;
    pos = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) begin
        pos = PosW'(i);
      end
    end
    return pos;
  endfunction

  function automatic operand_t normalize(input logic s, input logic signed [InExpW-1:0] e,
                                         input mant_t m);
    operand_t        r;
    logic [PosW-1:0] off;
    r.sign = s;
    off = '0;
    if (m == '0) begin
      r.exponent = exp_t'(e) - exp_t'(MantW);
      r.mantissa = '0;
    end else begin
      off = PosW'(NormPos) - top_bit({1'b0, m});
      r.mantissa = m << off;
      r.exponent = exp_t'(e) - exp_t'(off);
    end
    return r;
  endfunction

  // A right shift in which every lost bit is folded into bit 0; a negative
  // amount shifts left.
  function automatic wide_t sticky_shr(input wide_t a, input exp_t amt);
    wide_t           r;
    wide_t           mask;
    logic [ExpW-1:0] neg;
    r = a;
    mask = '0;
    neg = -amt;
    if (amt < 0) begin
      if (neg >= ExpW'(WideW)) begin
        r = '0;
      end else begin
        r = a << neg[PosW-1:0];
      end
    end else if (amt >= exp_t'(WideW)) begin
      r = {{(WideW-1){1'b0}}, |a};
    end else begin
      mask = ~({WideW{1'b1}} << amt[PosW-1:0]);
      r = a >> amt[PosW-1:0];
      r[0] = r[0] | (|(a & mask));
    end
    return r;
  endfunction

endpackage

@@ hdl/unpacked_fused_multiply_add_top.sv @@
// ----------------------------------------------------------------------------
// unpacked_fused_multiply_add_top
// Unrounded fused multiply-add on unpacked sign, exponent, mantissa operands.
// ----------------------------------------------------------------------------
// A transaction is started by raising start with the three operands on the
// in_ ports; busy is always low, so a new transaction may start in every
// cycle. The result is loaded into the out_ ports by the last stage, marked by
// a one-cycle out_valid strobe, and is taken at the following edge.
// The pipeline has eight register stages: normalisation, four partial
// products, product summation, path selection, sticky alignment shift, the
// 128-bit add or subtract, leading-one search and the final renormalising
// shift into the output registers. Throughput is one transaction per cycle.
// Reset clears the valid bits of all stages; transactions in flight are
// dropped and no strobe follows. The receiver cannot stall the block.
// ----------------------------------------------------------------------------
module unpacked_fused_multiply_add_top
  import ufma_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_addend_sign,
  input  logic signed [InExpW-1:0]  in_addend_exponent,
  input  logic [MantW-1:0]          in_addend_mantissa,
  input  logic                      in_mul_a_sign,
  input  logic signed [InExpW-1:0]  in_mul_a_exponent,
  input  logic [MantW-1:0]          in_mul_a_mantissa,
  input  logic                      in_mul_b_sign,
  input  logic signed [InExpW-1:0]  in_mul_b_exponent,
  input  logic [MantW-1:0]          in_mul_b_mantissa,
  output logic                      out_valid,
  output logic                      out_sum_sign,
  output logic signed [OutExpW-1:0] out_sum_exponent,
  output logic [MantW-1:0]          out_sum_mantissa
);

  logic [Latency-2:0] vld_r;

  operand_t a1_r, x1_r, y1_r;

  logic [63:0] p0_r;
  logic [62:0] p1_r, p2_r;
  logic [61:0] p3_r;
  logic        ps2_r, pz2_r, az2_r, as2_r;
  exp_t        pe2_r, ae2_r;
  mant_t       am2_r;

  wide_t pv3_r;
  logic  ps3_r, pz3_r, az3_r, as3_r;
  exp_t  pe3_r, ae3_r;
  mant_t am3_r;

  wide_t x4_r, y4_r, x4_nxt, y4_nxt;
  exp_t  amt4_r, amt4_nxt, re4_r, re4_nxt;
  logic  sub4_r, sub4_nxt, rs4_r, rs4_nxt, nrm4_r, nrm4_nxt;

  wide_t x5_r, y5_r;
  exp_t  re5_r;
  logic  sub5_r, rs5_r, nrm5_r;

  wide_t r6_r;
  exp_t  re6_r;
  logic  rs6_r, nrm6_r;

  wide_t           r7_r;
  exp_t            re7_r;
  logic            rs7_r, hz7_r;
  logic [PosW-1:0] sh7_r, sh7_nxt;

  wide_t pv4, along4, v8;
  exp_t  pe4, diff4, e8;
  logic  gt4;
  logic [63:0] m8;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      vld_r     <= {vld_r[Latency-3:0], start & ~busy};
      out_valid <= vld_r[Latency-2];
    end
  end

  // Stage 1: normalisation.
  always_ff @(posedge clk) begin
    a1_r <= normalize(in_addend_sign, in_addend_exponent, in_addend_mantissa);
    x1_r <= normalize(in_mul_a_sign, in_mul_a_exponent, in_mul_a_mantissa);
    y1_r <= normalize(in_mul_b_sign, in_mul_b_exponent, in_mul_b_mantissa);
  end

  // Stage 2: partial products.
  always_ff @(posedge clk) begin
    p0_r  <= 64'(x1_r.mantissa[31:0] * y1_r.mantissa[31:0]);
    p1_r  <= 63'(x1_r.mantissa[31:0] * y1_r.mantissa[62:32]);
    p2_r  <= 63'(x1_r.mantissa[62:32] * y1_r.mantissa[31:0]);
    p3_r  <= 62'(x1_r.mantissa[62:32] * y1_r.mantissa[62:32]);
    ps2_r <= x1_r.sign ^ y1_r.sign;
    pe2_r <= x1_r.exponent + y1_r.exponent;
    pz2_r <= ~x1_r.mantissa[NormPos] | ~y1_r.mantissa[NormPos];
    az2_r <= ~a1_r.mantissa[NormPos];
    as2_r <= a1_r.sign;
    ae2_r <= a1_r.exponent;
    am2_r <= a1_r.mantissa;
  end

  // Stage 3: product summation.
  always_ff @(posedge clk) begin
    pv3_r <= {2'b00, p3_r, p0_r}
             + {32'b0, 64'(65'(p1_r) + 65'(p2_r)), 32'b0};
    ps3_r <= ps2_r;
    pe3_r <= pe2_r;
    pz3_r <= pz2_r;
    az3_r <= az2_r;
    as3_r <= as2_r;
    ae3_r <= ae2_r;
    am3_r <= am2_r;
  end

  // Stage 4: product adjustment and path selection.
  always_comb begin
    if (pv3_r[2*NormPos+1]) begin
      pv4 = pv3_r >> 1;
      pe4 = pe3_r + exp_t'(1);
    end else begin
      pv4 = pv3_r;
      pe4 = pe3_r;
    end
    diff4  = pe4 - ae3_r + exp_t'(NormPos);
    along4 = wide_t'(am3_r) << NormPos;
    gt4    = pv4 > along4;
    x4_nxt   = pv4;
    y4_nxt   = '0;
    amt4_nxt = '0;
    sub4_nxt = 1'b0;
    rs4_nxt  = ps3_r;
    re4_nxt  = pe4;
    nrm4_nxt = 1'b0;
    if (pz3_r) begin
      x4_nxt  = wide_t'(am3_r);
      rs4_nxt = as3_r;
      re4_nxt = ae3_r;
    end else if (az3_r) begin
      x4_nxt = pv4;
    end else if (ps3_r == as3_r) begin
      if (diff4 <= 0) begin
        x4_nxt   = wide_t'(am3_r);
        y4_nxt   = pv4;
        amt4_nxt = exp_t'(NormPos) - diff4;
        rs4_nxt  = as3_r;
        re4_nxt  = ae3_r;
      end else begin
        y4_nxt   = wide_t'(am3_r);
        amt4_nxt = diff4 - exp_t'(NormPos);
      end
    end else begin
      sub4_nxt = 1'b1;
      nrm4_nxt = 1'b1;
      if (diff4 > 0 || (diff4 == 0 && gt4)) begin
        y4_nxt   = along4;
        amt4_nxt = diff4;
      end else begin
        x4_nxt   = along4;
        y4_nxt   = pv4;
        amt4_nxt = -diff4;
        rs4_nxt  = ~ps3_r;
        re4_nxt  = ae3_r - exp_t'(NormPos);
      end
    end
  end

  always_ff @(posedge clk) begin
    x4_r   <= x4_nxt;
    y4_r   <= y4_nxt;
    amt4_r <= amt4_nxt;
    sub4_r <= sub4_nxt;
    rs4_r  <= rs4_nxt;
    re4_r  <= re4_nxt;
    nrm4_r <= nrm4_nxt;
  end

  // Stage 5: sticky alignment.
  always_ff @(posedge clk) begin
    x5_r   <= x4_r;
    y5_r   <= sticky_shr(y4_r, amt4_r);
    sub5_r <= sub4_r;
    rs5_r  <= rs4_r;
    re5_r  <= re4_r;
    nrm5_r <= nrm4_r;
  end

  // Stage 6: addition or subtraction.
  always_ff @(posedge clk) begin
    r6_r   <= sub5_r ? (x5_r - y5_r) : (x5_r + y5_r);
    rs6_r  <= rs5_r;
    re6_r  <= re5_r;
    nrm6_r <= nrm5_r;
  end

  // Stage 7: leading-one search.
  always_comb begin
    sh7_nxt = '0;
    if (r6_r[WideW-1:64] != '0 && nrm6_r) begin
      sh7_nxt = PosW'(NormPos) - top_bit(r6_r[WideW-1:64]);
    end
  end

  always_ff @(posedge clk) begin
    r7_r  <= r6_r;
    re7_r <= re6_r;
    rs7_r <= rs6_r;
    hz7_r <= r6_r[WideW-1:64] == '0;
    sh7_r <= sh7_nxt;
  end

  // Stage 8: renormalisation and output.
  always_comb begin
    v8 = r7_r << sh7_r;
    if (hz7_r) begin
      m8 = v8[63:0];
      e8 = re7_r;
    end else begin
      m8 = v8[WideW-1:64] | {63'b0, |v8[63:0]};
      e8 = re7_r - exp_t'(sh7_r) + exp_t'(64);
    end
    if (m8[63]) begin
      m8 = (m8 >> 1) | {63'b0, m8[0]};
      e8 = e8 + exp_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    out_sum_sign     <= rs7_r;
    out_sum_exponent <= e8[OutExpW-1:0];
    out_sum_mantissa <= m8[MantW-1:0];
  end

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(Latency) out_valid)
    else $error("A started transaction did not produce a result strobe.");

  a_norm : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> (x1_r.mantissa[NormPos] || x1_r.mantissa == '0))
    else $error("A factor mantissa left stage one unnormalised.");

  a_range : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> r6_r[WideW-1:WideW-2] == 2'b00)
    else $error("The adder result overflowed or went negative.");

endmodule

@@ test/ufma_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ufma_checker
// Watches the operand and result channels of the fused multiply-add, works
// out the exact unrounded result of every accepted transaction and compares
// each strobed result, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module ufma_checker
  import ufma_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      in_addend_sign,
  input  logic signed [InExpW-1:0]  in_addend_exponent,
  input  logic [MantW-1:0]          in_addend_mantissa,
  input  logic                      in_mul_a_sign,
  input  logic signed [InExpW-1:0]  in_mul_a_exponent,
  input  logic [MantW-1:0]          in_mul_a_mantissa,
  input  logic                      in_mul_b_sign,
  input  logic signed [InExpW-1:0]  in_mul_b_exponent,
  input  logic [MantW-1:0]          in_mul_b_mantissa,
  input  logic                      out_valid,
  input  logic                      out_sum_sign,
  input  logic signed [OutExpW-1:0] out_sum_exponent,
  input  logic [MantW-1:0]          out_sum_mantissa,
  output int                        fail_count,
  output int                        pending_sums
);

  typedef struct packed {
    logic               sign;
    logic [OutExpW-1:0] exponent;
    logic [MantW-1:0]   mantissa;
  } fused_sum_t;

  fused_sum_t sum_queue[$];

  function automatic int msb_index(input logic [63:0] x);
    int n;
    n = -1;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) begin
        n = i;
      end
    end
    return n;
  endfunction

  function automatic logic [127:0] shift_sticky(input logic [127:0] a, input int amt);
    logic [127:0] r;
    if (amt < 0) begin
      r = (-amt >= 128) ? '0 : a << (-amt);
    end else if (amt == 0) begin
      r = a;
    end else if (amt >= 128) begin
      r = {127'd0, |a};
    end else begin
      r = a >> amt;
      if ((r << amt) != a) begin
        r[0] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic fused_sum_t pack_sum(input logic s, input int e, input logic [63:0] m);
    fused_sum_t r;
    logic [63:0] mm;
    int          ee;
    mm = m;
    ee = e;
    if (mm[63]) begin
      mm = (mm >> 1) | {63'd0, m[0]};
      ee = ee + 1;
    end
    r.sign     = s;
    r.exponent = ee[OutExpW-1:0];
    r.mantissa = mm[MantW-1:0];
    return r;
  endfunction

  function automatic fused_sum_t pack_wide(input logic s, input int e, input logic [127:0] v);
    return pack_sum(s, e + 64, v[127:64] | {63'd0, |v[63:0]});
  endfunction

  function automatic void norm_operand(inout int e, inout logic [63:0] m);
    int off;
    if (m == 0) begin
      e = e - 63;
    end else begin
      off = NormPos - msb_index(m);
      m = m << off;
      e = e - off;
    end
  endfunction

  function automatic fused_sum_t fused_sum(
    input logic as_i, input logic signed [InExpW-1:0] ae_i, input logic [MantW-1:0] am_i,
    input logic xs, input logic signed [InExpW-1:0] xe_i, input logic [MantW-1:0] xm_i,
    input logic ys, input logic signed [InExpW-1:0] ye_i, input logic [MantW-1:0] ym_i);
    int           ae, xe, ye, pe, re, diff, sh;
    logic [63:0]  am, xm, ym;
    logic         ps, rs;
    logic [127:0] pv, rv, along, am_w, shv;
    ae = ae_i;
    xe = xe_i;
    ye = ye_i;
    am = {1'b0, am_i};
    xm = {1'b0, xm_i};
    ym = {1'b0, ym_i};
    norm_operand(ae, am);
    norm_operand(xe, xm);
    norm_operand(ye, ym);
    ps = xs ^ ys;
    pe = xe + ye;
    pv = {64'd0, xm} * {64'd0, ym};
    if (pv[125]) begin
      pv = pv >> 1;
      pe = pe + 1;
    end
    if (pv == 0) begin
      return pack_sum(as_i, ae, am);
    end
    if (am == 0) begin
      return pack_wide(ps, pe, pv);
    end
    diff = pe - (ae - NormPos);
    am_w = {64'd0, am};
    if (ps == as_i) begin
      if (diff <= 0) begin
        shv = shift_sticky(pv, NormPos - diff);
        return pack_sum(as_i, ae, am + shv[63:0]);
      end
      rv = pv + shift_sticky(am_w, diff - NormPos);
      return pack_wide(ps, pe, rv);
    end
    along = am_w << NormPos;
    if (diff == 0 && pv > along) begin
      rs = ps;
      re = pe;
      rv = pv - along;
    end else if (diff <= 0) begin
      rs = !ps;
      re = ae - NormPos;
      rv = along - shift_sticky(pv, -diff);
    end else begin
      rs = ps;
      re = pe;
      rv = pv - shift_sticky(along, diff);
    end
    if (rv[127:64] == 0) begin
      return pack_sum(rs, re, rv[63:0]);
    end
    sh = NormPos - msb_index(rv[127:64]);
    if (sh > 0) begin
      rv = rv << sh;
      re = re - sh;
    end
    return pack_wide(rs, re, rv);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    fail_count = fail_count + 1;
  endtask

  initial begin
    fail_count = 0;
  end

  assign pending_sums = sum_queue.size();

  always @(posedge clk) begin
    fused_sum_t want;
    if (rst_n && start && !busy) begin
      sum_queue.push_back(fused_sum(
        in_addend_sign, in_addend_exponent, in_addend_mantissa,
        in_mul_a_sign, in_mul_a_exponent, in_mul_a_mantissa,
        in_mul_b_sign, in_mul_b_exponent, in_mul_b_mantissa));
    end
    if (rst_n && out_valid) begin
      if (sum_queue.size() == 0) begin
        report_mismatch("unexpected result", {out_sum_sign, out_sum_mantissa}, '0);
      end else begin
        want = sum_queue.pop_front();
        if (out_sum_sign !== want.sign) begin
          report_mismatch("sign", out_sum_sign, want.sign);
        end
        if (out_sum_exponent !== want.exponent) begin
          report_mismatch("exponent", out_sum_exponent, want.exponent);
        end
        if (out_sum_mantissa !== want.mantissa) begin
          report_mismatch("mantissa", out_sum_mantissa, want.mantissa);
        end
      end
    end
  end

endmodule

@@ test/tb_unpacked_fused_multiply_add_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unpacked_fused_multiply_add_top
// Drives directed and random operand triples into the fused multiply-add with
// random start gaps and lets the checker compare every result; a watchdog
// ends the run if the channels go quiet.
// ----------------------------------------------------------------------------
module tb_unpacked_fused_multiply_add_top;
  import ufma_pkg::*;

  localparam int RandomOps  = 1600;
  localparam int QuietLimit = 1000;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_addend_sign;
  logic signed [InExpW-1:0]  in_addend_exponent;
  logic [MantW-1:0]          in_addend_mantissa;
  logic                      in_mul_a_sign;
  logic signed [InExpW-1:0]  in_mul_a_exponent;
  logic [MantW-1:0]          in_mul_a_mantissa;
  logic                      in_mul_b_sign;
  logic signed [InExpW-1:0]  in_mul_b_exponent;
  logic [MantW-1:0]          in_mul_b_mantissa;
  logic                      out_valid;
  logic                      out_sum_sign;
  logic signed [OutExpW-1:0] out_sum_exponent;
  logic [MantW-1:0]          out_sum_mantissa;
  int                        fail_count;
  int                        pending_sums;
  int                        quiet_cycles;

  localparam logic [MantW-1:0] MantMax = {MantW{1'b1}};
  localparam logic signed [InExpW-1:0] ExpMin = -13'sd4096;
  localparam logic signed [InExpW-1:0] ExpMax = 13'sd4095;

  unpacked_fused_multiply_add_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_addend_sign     (in_addend_sign),
    .in_addend_exponent (in_addend_exponent),
    .in_addend_mantissa (in_addend_mantissa),
    .in_mul_a_sign      (in_mul_a_sign),
    .in_mul_a_exponent  (in_mul_a_exponent),
    .in_mul_a_mantissa  (in_mul_a_mantissa),
    .in_mul_b_sign      (in_mul_b_sign),
    .in_mul_b_exponent  (in_mul_b_exponent),
    .in_mul_b_mantissa  (in_mul_b_mantissa),
    .out_valid          (out_valid),
    .out_sum_sign       (out_sum_sign),
    .out_sum_exponent   (out_sum_exponent),
    .out_sum_mantissa   (out_sum_mantissa)
  );

  ufma_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_addend_sign     (in_addend_sign),
    .in_addend_exponent (in_addend_exponent),
    .in_addend_mantissa (in_addend_mantissa),
    .in_mul_a_sign      (in_mul_a_sign),
    .in_mul_a_exponent  (in_mul_a_exponent),
    .in_mul_a_mantissa  (in_mul_a_mantissa),
    .in_mul_b_sign      (in_mul_b_sign),
    .in_mul_b_exponent  (in_mul_b_exponent),
    .in_mul_b_mantissa  (in_mul_b_mantissa),
    .out_valid          (out_valid),
    .out_sum_sign       (out_sum_sign),
    .out_sum_exponent   (out_sum_exponent),
    .out_sum_mantissa   (out_sum_mantissa),
    .fail_count         (fail_count),
    .pending_sums       (pending_sums)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [MantW-1:0] pick_mantissa();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return MantMax;
      2:       return MantW'(r >> $urandom_range(1, 62));
      3:       return MantW'(1) << $urandom_range(0, 62);
      default: return r[MantW-1:0];
    endcase
  endfunction

  task automatic send_fma(input logic as, input int ae, input logic [MantW-1:0] am,
                          input logic xs, input int xe, input logic [MantW-1:0] xm,
                          input logic ys, input int ye, input logic [MantW-1:0] ym);
    in_addend_sign     <= as;
    in_addend_exponent <= InExpW'(ae);
    in_addend_mantissa <= am;
    in_mul_a_sign      <= xs;
    in_mul_a_exponent  <= InExpW'(xe);
    in_mul_a_mantissa  <= xm;
    in_mul_b_sign      <= ys;
    in_mul_b_exponent  <= InExpW'(ye);
    in_mul_b_mantissa  <= ym;
    start              <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic idle_gap(input int max_gap);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic [MantW-1:0] xm, ym;
    int               xe, ye, max_gap;
    logic             xs, ys;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_addend_sign <= 1'b0;
    in_addend_exponent <= '0;
    in_addend_mantissa <= '0;
    in_mul_a_sign <= 1'b0;
    in_mul_a_exponent <= '0;
    in_mul_a_mantissa <= '0;
    in_mul_b_sign <= 1'b0;
    in_mul_b_exponent <= '0;
    in_mul_b_mantissa <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_fma(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_fma(1, ExpMin, 0, 0, 5, 7, 1, 3, 0);
    send_fma(1, 100, 12345, 1, 7, 0, 0, 3, 99);
    send_fma(0, ExpMax, MantMax, 0, ExpMax, MantMax, 0, ExpMax, MantMax);
    send_fma(1, ExpMin, MantMax, 1, ExpMin, MantMax, 1, ExpMin, MantMax);
    send_fma(0, ExpMin, 1, 1, ExpMax, 1, 0, ExpMax, 1);
    send_fma(1, ExpMax, 1, 0, ExpMin, 1, 0, ExpMin, 1);
    send_fma(0, 0, 0, 1, 3, MantMax, 0, -9, 5);
    send_fma(1, 0, 6, 0, 0, 2, 0, 0, 3);
    send_fma(0, 4, 15, 1, 2, 5, 0, 2, 3);
    send_fma(0, 0, MantMax, 0, 0, MantMax, 0, 0, MantMax);
    send_fma(0, 62, MantMax, 0, 0, MantMax, 0, 0, MantMax);
    send_fma(1, 60, MantMax, 0, 0, MantMax, 0, 0, MantMax);
    send_fma(0, 0, 1, 1, 0, 1, 0, 0, 1);
    send_fma(0, 0, 3, 1, 0, 1, 0, 0, 1);
    send_fma(1, -300, 1, 0, 0, 1, 0, 0, 1);
    send_fma(0, 300, 1, 1, 0, 1, 0, 0, 1);
    send_fma(1, -200, MantMax, 0, 100, MantMax, 0, 100, MantMax);
    send_fma(0, 0, 63'h4000_0000_0000_0000, 1, 0, 63'h4000_0000_0000_0001, 0, 0,
             63'h4000_0000_0000_0000);
    send_fma(1, ExpMax, MantMax, 1, 2000, 1, 1, 2000, 1);

    for (int n = 0; n < RandomOps; n++) begin
      max_gap = ((n / 200) % 2 == 0) ? 9 : 0;
      idle_gap(max_gap);
      if (n == RandomOps / 2) begin
        start <= 1'b0;
        while (pending_sums != 0) @(posedge clk);
      end
      xs = $urandom_range(0, 1);
      ys = $urandom_range(0, 1);
      case ($urandom_range(0, 3))
        0: begin
          send_fma($urandom_range(0, 1), $signed(13'($urandom)), pick_mantissa(),
                   xs, $signed(13'($urandom)), pick_mantissa(),
                   ys, $signed(13'($urandom)), pick_mantissa());
        end
        1: begin
          xm = MantW'($urandom_range(1, 1 << 20));
          ym = MantW'($urandom_range(1, 1 << 20));
          xe = $urandom_range(0, 3800) - 1900;
          ye = $urandom_range(0, 3800) - 1900;
          xe = xe / 2;
          ye = ye / 2;
          send_fma(!(xs ^ ys), xe + ye, xm * ym, xs, xe, xm, ys, ye, ym);
        end
        default: begin
          xe = int'($urandom_range(0, 3800)) - 1900;
          ye = int'($urandom_range(0, 3800)) - 1900;
          xe = xe / 2;
          ye = ye / 2;
          send_fma($urandom_range(0, 1), xe + ye + int'($urandom_range(0, 140)) - 70,
                   pick_mantissa(), xs, xe, pick_mantissa(), ys, ye, pick_mantissa());
        end
      endcase
    end
    start <= 1'b0;
    while (pending_sums != 0) @(posedge clk);
    repeat (Latency + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ unpacked_fused_multiply_add_top.f @@
hdl/ufma_pkg.sv
hdl/unpacked_fused_multiply_add_top.sv
test/ufma_checker.sv
test/tb_unpacked_fused_multiply_add_top.sv
